### design/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// implication into the next cycle, outside of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

### design/aeg_pkg.sv
`default_nettype none

package aeg_pkg;

    localparam int unsigned LVL_W     = 24;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CODE_W    = 3;

    localparam logic [LVL_W-1:0] LVL_ONE = 24'h800000;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd3;

    localparam logic [LVL_W-1:0] RST_ATTACK  = 24'd1024;
    localparam logic [LVL_W-1:0] RST_DECAY   = 24'd512;
    localparam logic [LVL_W-1:0] RST_SUSTAIN = 24'd4194304;
    localparam logic [LVL_W-1:0] RST_RELEASE = 24'd512;

    localparam logic [CODE_W-1:0] CODE_IDLE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ATTACK  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DECAY   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_ATTACK  = 5'b00010,
        ST_DECAY   = 5'b00100,
        ST_SUSTAIN = 5'b01000,
        ST_RELEASE = 5'b10000
    } t_stage;

    typedef struct packed {
        logic [LVL_W-1:0] atk_step;
        logic [LVL_W-1:0] dcy_step;
        logic [LVL_W-1:0] sustain_level;
        logic [LVL_W-1:0] rel_step;
    } t_cfg;

    function automatic logic [LVL_W-1:0] sustain_clamp(input logic [LVL_W-1:0] sus);
        return (sus > LVL_ONE) ? LVL_ONE : sus;
    endfunction

    function automatic logic [CODE_W-1:0] stage_code(input t_stage st);
        logic [CODE_W-1:0] code;
        case (st)
            ST_ATTACK:  code = CODE_ATTACK;
            ST_DECAY:   code = CODE_DECAY;
            ST_SUSTAIN: code = CODE_SUSTAIN;
            ST_RELEASE: code = CODE_RELEASE;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

    // stage change at the start of a chunk
    function automatic t_stage gate_adjust(input t_stage st, input logic gate);
        t_stage res;
        logic   quiet;
        quiet = (st == ST_IDLE) || (st == ST_RELEASE);
        if (gate && quiet) begin
            res = ST_ATTACK;
        end else if (!gate && !quiet) begin
            res = ST_RELEASE;
        end else begin
            res = st;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/aeg_cfg.sv
`default_nettype none

module aeg_cfg
    import aeg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LVL_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atk_step      <= RST_ATTACK;
            r_cfg.dcy_step      <= RST_DECAY;
            r_cfg.sustain_level <= RST_SUSTAIN;
            r_cfg.rel_step      <= RST_RELEASE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ATTACK:  r_cfg.atk_step      <= i_cfg_data;
                REG_DECAY:   r_cfg.dcy_step      <= i_cfg_data;
                REG_SUSTAIN: r_cfg.sustain_level <= i_cfg_data;
                REG_RELEASE: r_cfg.rel_step      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/aeg_step.sv
`default_nettype none

module aeg_step
    import aeg_pkg::*;
(
    input  t_cfg                  i_cfg,
    input  t_stage                i_stage,
    input  wire logic [LVL_W-1:0] i_level,
    output t_stage                o_stage,
    output logic      [LVL_W-1:0] o_level
);

    logic [LVL_W-1:0] sus;
    logic [LVL_W:0]   att_sum;
    logic [LVL_W:0]   dec_lim;

    always_comb begin
        sus     = sustain_clamp(i_cfg.sustain_level);
        att_sum = {1'b0, i_level} + {1'b0, i_cfg.atk_step};
        dec_lim = {1'b0, sus} + {1'b0, i_cfg.dcy_step};
        o_stage = i_stage;
        o_level = i_level;
        case (i_stage)
            ST_ATTACK: begin
                if (att_sum >= {1'b0, LVL_ONE}) begin
                    o_level = LVL_ONE;
                    o_stage = ST_DECAY;
                end else begin
                    o_level = att_sum[LVL_W-1:0];
                end
            end
            ST_DECAY: begin
                if ({1'b0, i_level} <= dec_lim) begin
                    o_level = sus;
                    o_stage = ST_SUSTAIN;
                end else begin
                    o_level = i_level - i_cfg.dcy_step;
                end
            end
            ST_SUSTAIN: begin
                o_level = sus;
            end
            ST_RELEASE: begin
                if (i_level <= i_cfg.rel_step) begin
                    o_level = '0;
                    o_stage = ST_IDLE;
                end else begin
                    o_level = i_level - i_cfg.rel_step;
                end
            end
            default: begin
                o_level = '0;
                o_stage = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/adsr_envelope_generator.sv
// Linear ADSR envelope generator.
// Input channel (i_valid / o_stall): one beat per chunk, carrying the gate bit.
// Output channel (o_valid / i_stall): CHUNK_LEN envelope samples per chunk,
// each with its level (unsigned Q1.23), the stage after the sample, and a
// flag on the last sample of the chunk.
// Config channel (i_cfg_valid / o_cfg_ready): always ready; writes attack,
// decay, sustain and release values by index, unknown indexes are dropped.
// Write configuration only while no chunk is in flight.
// A taken chunk sets the busy flag; its first sample is then registered in
// the output register. Throughput: one sample per cycle while no stall holds
// the output; the next chunk is taken in the cycle of the current last
// sample, so samples stream without gaps, and the counter marks that sample.
// Reset: stage idle, level zero, all rates back to their defaults, no
// output pending. A stall on the output holds the sample in the output
// register and freezes the generator; a busy generator stalls its input as well.
`default_nettype none
`include "assert_macros.svh"

module adsr_envelope_generator
    import aeg_pkg::*;
#(
    parameter int unsigned CHUNK_LEN = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_gate_on,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic      [LVL_W-1:0]     o_env_level,
    output logic      [CODE_W-1:0]    o_env_stage,
    output logic                      o_last_of_chunk,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LVL_W-1:0]     i_cfg_data
);

    localparam int unsigned CNT_W = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CHUNK_LEN - 1);

    t_cfg             cfg;
    t_stage           step_stage;
    logic [LVL_W-1:0] step_level;

    t_stage           r_stage, n_stage;
    logic [LVL_W-1:0] r_level, n_level;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_out_valid;
    logic [LVL_W-1:0] r_out_level;
    logic [CODE_W-1:0] r_out_stage;
    logic             r_out_last;

    logic             accept_in;
    logic             advance;
    logic             last;
    t_stage           base_stage;

    aeg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    aeg_step u_step (
        .i_cfg   (cfg),
        .i_stage (r_stage),
        .i_level (r_level),
        .o_stage (step_stage),
        .o_level (step_level)
    );

    always_comb begin
        advance    = r_busy && (!r_out_valid || !i_stall);
        last       = (r_cnt == LAST_CNT);
        o_stall    = r_busy && !(advance && last);
        accept_in  = i_valid && !o_stall;
        base_stage = advance ? step_stage : r_stage;
        n_level    = advance ? step_level : r_level;
        n_stage    = accept_in ? gate_adjust(base_stage, i_gate_on) : base_stage;
        if (accept_in) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (advance && last) begin
            n_busy = 1'b0;
            n_cnt  = '0;
        end else if (advance) begin
            n_busy = r_busy;
            n_cnt  = r_cnt + 1'b1;
        end else begin
            n_busy = r_busy;
            n_cnt  = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_level     <= '0;
            r_cnt       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
            r_level <= n_level;
            r_cnt   <= n_cnt;
            r_busy  <= n_busy;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level <= step_level;
            r_out_stage <= stage_code(step_stage);
            r_out_last  <= last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_env_level     = r_out_level;
    assign o_env_stage     = r_out_stage;
    assign o_last_of_chunk = r_out_last;
    assign o_cfg_ready     = 1'b1;

    `ASSERT_CLK(a_level_max, i_clk, i_rst_n, o_valid |-> (o_env_level <= LVL_ONE), "level above one")
    `ASSERT_CLK(a_idle_zero, i_clk, i_rst_n, (o_valid && (o_env_stage == CODE_IDLE)) |-> (o_env_level == '0), "idle sample with nonzero level")
    `ASSERT_CLK(a_sustain_hold, i_clk, i_rst_n, (o_valid && (o_env_stage == CODE_SUSTAIN)) |-> (o_env_level == sustain_clamp(cfg.sustain_level)), "sustain sample off the sustain level")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept_in, r_busy && (r_cnt == '0), "chunk taken but generator not started")

endmodule

`default_nettype wire

### test/tb_adsr_envelope_generator.sv
`timescale 1ns / 1ps

module tb_adsr_envelope_generator;
    import aeg_pkg::*;

    localparam int CHUNK = 32;
    localparam int PHASES = 8;
    localparam int CHUNKS_PER_PHASE = 56;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_REPORTS = 10;
    localparam logic [LVL_W-1:0] LVL_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_RELEASE + 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = '1;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [CODE_W-1:0] stage;
        logic              last_flag;
    } t_env_sample;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_gate_on;
    logic                 o_valid;
    logic                 i_stall;
    logic [LVL_W-1:0]     o_env_level;
    logic [CODE_W-1:0]    o_env_stage;
    logic                 o_last_of_chunk;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LVL_W-1:0]     i_cfg_data;

    t_env_sample samples_due[$];
    t_env_sample due_s;

    logic [LVL_W-1:0]  atk_rate = RST_ATTACK;
    logic [LVL_W-1:0]  dcy_rate = RST_DECAY;
    logic [LVL_W-1:0]  sus_level = RST_SUSTAIN;
    logic [LVL_W-1:0]  rel_rate = RST_RELEASE;
    logic [CODE_W-1:0] env_stage = CODE_IDLE;
    logic [LVL_W-1:0]  env_level = '0;

    int  errors = 0;
    int  samples_checked = 0;
    int  chunks_taken = 0;
    int  settings_used = 1;
    int  cycles = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b0;

    adsr_envelope_generator #(
        .CHUNK_LEN(CHUNK)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_gate_on      (i_gate_on),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_env_level    (o_env_level),
        .o_env_stage    (o_env_stage),
        .o_last_of_chunk(o_last_of_chunk),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic generate_chunk_samples(input logic gate);
        logic [LVL_W-1:0] sus_eff;
        logic [LVL_W:0]   sum;
        logic             quiet;
        t_env_sample      s;
        int               k;
        sus_eff = (sus_level > LVL_ONE) ? LVL_ONE : sus_level;
        quiet = (env_stage == CODE_IDLE) || (env_stage == CODE_RELEASE);
        if (gate && quiet) begin
            env_stage = CODE_ATTACK;
        end else if (!gate && !quiet) begin
            env_stage = CODE_RELEASE;
        end
        for (k = 0; k < CHUNK; k++) begin
            case (env_stage)
                CODE_ATTACK: begin
                    sum = {1'b0, env_level} + {1'b0, atk_rate};
                    if (sum >= {1'b0, LVL_ONE}) begin
                        env_level = LVL_ONE;
                        env_stage = CODE_DECAY;
                    end else begin
                        env_level = sum[LVL_W-1:0];
                    end
                end
                CODE_DECAY: begin
                    sum = {1'b0, sus_eff} + {1'b0, dcy_rate};
                    if ({1'b0, env_level} <= sum) begin
                        env_level = sus_eff;
                        env_stage = CODE_SUSTAIN;
                    end else begin
                        env_level = env_level - dcy_rate;
                    end
                end
                CODE_SUSTAIN: begin
                    env_level = sus_eff;
                end
                CODE_RELEASE: begin
                    if (env_level <= rel_rate) begin
                        env_level = '0;
                        env_stage = CODE_IDLE;
                    end else begin
                        env_level = env_level - rel_rate;
                    end
                end
                default: begin
                    env_level = '0;
                    env_stage = CODE_IDLE;
                end
            endcase
            s.level = env_level;
            s.stage = env_stage;
            s.last_flag = (k == CHUNK - 1);
            samples_due.push_back(s);
        end
    endtask

    // register writes and chunk beats as the block takes them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ATTACK:  atk_rate = i_cfg_data;
                    REG_DECAY:   dcy_rate = i_cfg_data;
                    REG_SUSTAIN: sus_level = i_cfg_data;
                    REG_RELEASE: rel_rate = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                generate_chunk_samples(i_gate_on);
                chunks_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (samples_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("sample with none due: level %h stage %0d last %b",
                             o_env_level, o_env_stage, o_last_of_chunk);
                end
            end else begin
                due_s = samples_due.pop_front();
                if (o_env_level !== due_s.level || o_env_stage !== due_s.stage ||
                    o_last_of_chunk !== due_s.last_flag) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("sample %0d: expected level %h stage %0d last %b,",
                                 samples_checked, due_s.level, due_s.stage,
                                 due_s.last_flag);
                        $display("    got level %h stage %0d last %b",
                                 o_env_level, o_env_stage, o_last_of_chunk);
                    end
                end
                samples_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d samples outstanding",
                     cycles, samples_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output backpressure: mostly short stalls, a few long ones
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [LVL_W-1:0] pick_rate();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return '0;
            1: return LVL_MAX;
            2: return LVL_ONE;
            3, 4, 5, 6, 7, 8, 9: return LVL_W'($urandom_range(1, 24'h020000));
            default: return LVL_W'($urandom_range(24'h020000, 24'h400000));
        endcase
    endfunction

    function automatic logic [LVL_W-1:0] pick_sustain();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return LVL_ONE;
            2: return LVL_MAX;
            3: return LVL_W'($urandom_range(LVL_ONE + 1, LVL_MAX));
            default: return LVL_W'($urandom_range(1, LVL_ONE - 1));
        endcase
    endfunction

    // one chunk beat; valid stays up unless a gap follows
    task automatic send_chunk(input logic gate);
        int gap;
        i_valid <= 1'b1;
        i_gate_on <= gate;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_gate_on <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_samples_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (samples_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic quiesce();
        wait_samples_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_envelope(input logic [LVL_W-1:0] a, input logic [LVL_W-1:0] d,
                                input logic [LVL_W-1:0] s, input logic [LVL_W-1:0] r);
        quiesce();
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, s);
        write_reg(REG_RELEASE, r);
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_chunk(1'b0);
        send_chunk(1'b1);
        send_chunk(1'b0);
        send_chunk(1'b0);
    endtask

    task automatic test_full_envelope();
        set_envelope(24'h100000, 24'h040000, 24'h300000, 24'h060000);
        send_chunk(1'b1);
        send_chunk(1'b1);
        send_chunk(1'b1);
        send_chunk(1'b0);
        send_chunk(1'b1);
        send_chunk(1'b0);
        send_chunk(1'b0);
    endtask

    task automatic test_extreme_rates();
        // overshoot and undershoot clamps, sustain above full scale
        set_envelope(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX);
        send_chunk(1'b1);
        send_chunk(1'b0);
        set_envelope(LVL_ONE, LVL_ONE, '0, LVL_ONE);
        send_chunk(1'b1);
        send_chunk(1'b0);
        set_envelope(LVL_ONE, '0, LVL_ONE, 24'h000001);
        send_chunk(1'b1);
        send_chunk(1'b0);
    endtask

    task automatic test_zero_rates();
        set_envelope('0, 24'h040000, 24'h400000, '0);
        send_chunk(1'b1);
        send_chunk(1'b0);
        set_envelope(LVL_ONE, 24'h040000, 24'h400000, '0);
        send_chunk(1'b1);
        send_chunk(1'b0);
        send_chunk(1'b1);
    endtask

    task automatic test_sustain_raise();
        set_envelope(LVL_ONE, 24'h008000, 24'h200000, LVL_ONE);
        send_chunk(1'b1);
        // still in decay, new sustain sits above the current level
        quiesce();
        write_reg(REG_SUSTAIN, 24'h780000);
        settings_used++;
        send_chunk(1'b1);
        send_chunk(1'b0);
    endtask

    task automatic test_unknown_index();
        quiesce();
        write_reg(REG_LAST_UNUSED, LVL_W'($urandom_range(0, LVL_MAX)));
        write_reg(REG_FIRST_UNUSED, LVL_MAX);
        write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED + 1, REG_LAST_UNUSED - 1)),
                  LVL_W'($urandom_range(0, LVL_MAX)));
        send_chunk(1'b1);
    endtask

    task automatic test_random_envelopes();
        int  p;
        int  sent;
        int  hold;
        bit  paused;
        for (p = 0; p < PHASES; p++) begin
            set_envelope(pick_rate(), pick_rate(), pick_sustain(), pick_rate());
            idle_on = (p % 3) != 1;
            sent = 0;
            paused = 1'b0;
            while (sent < CHUNKS_PER_PHASE) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_chunk(1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    hold = $urandom_range(1, 10);
                    while (hold > 0 && sent < CHUNKS_PER_PHASE) begin
                        send_chunk(1'b1);
                        sent++;
                        hold--;
                    end
                    hold = $urandom_range(1, 6);
                    while (hold > 0 && sent < CHUNKS_PER_PHASE) begin
                        send_chunk(1'b0);
                        sent++;
                        hold--;
                    end
                end
                if (!paused && (p % 4) == 2 && sent >= CHUNKS_PER_PHASE / 2) begin
                    wait_samples_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_gate_on = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_on = 1'b1;

        test_reset_defaults();
        test_full_envelope();
        test_extreme_rates();
        test_zero_rates();
        test_sustain_raise();
        test_unknown_index();
        test_random_envelopes();

        wait_samples_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("%0d chunks, %0d envelope samples checked across %0d register settings",
                 chunks_taken, samples_checked, settings_used);
        $display("%0d mismatches, %0d samples still due", errors, samples_due.size());
        if (errors == 0 && samples_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/aeg_pkg.sv
design/aeg_cfg.sv
design/aeg_step.sv
design/adsr_envelope_generator.sv
test/tb_adsr_envelope_generator.sv
